@@ rtl/bf3_pkg.sv @@
// Shared constants, types and helpers of the 3x3 box filter.
package bf3_pkg;

   // Frame limits and field widths.
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int MIN_DIM    = 3;
   localparam int DIM_W      = 10;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int PIX_W      = 8;
   localparam int POS_W      = 9;
   localparam int CSR_IDX_W  = 4;

   // Window arithmetic: one column sum, the nine-pixel sum, and the
   // reciprocal of nine that gives an exact floor for sums up to 9 * 255.
   localparam int COL_W       = 10;
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

   // Control of the two line stores.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [PIX_W-1:0]  wr_pixel;
   } ls_ctrl_type;

   // Clamps a written dimension into [MIN_DIM, maxv].
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(MIN_DIM)) begin
         r = DIM_W'(MIN_DIM);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ rtl/bf3_channels.sv @@
// Channel interfaces of the 3x3 box filter: pixel input, result output, register writes.
interface bf3_pixel_if;
   logic                        valid;
   logic                        ready;
   logic [bf3_pkg::PIX_W-1:0]   pixel_in;
   logic                        drain;
   modport source (output valid, pixel_in, drain, input ready);
   modport sink   (input valid, pixel_in, drain, output ready);
endinterface

interface bf3_result_if;
   logic                        valid;
   logic                        ready;
   logic [bf3_pkg::PIX_W-1:0]   pixel_out;
   logic [bf3_pkg::POS_W-1:0]   out_row;
   logic [bf3_pkg::POS_W-1:0]   out_col;
   logic                        frame_end;
   modport source (output valid, pixel_out, out_row, out_col, frame_end, input ready);
   modport sink   (input valid, pixel_out, out_row, out_col, frame_end, output ready);
endinterface

interface bf3_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bf3_pkg::CSR_IDX_W-1:0] index;
   logic [bf3_pkg::DIM_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bf3_line_store.sv @@
// Two line stores holding the previous two rows, with registered reads.
module bf3_line_store (
   input  logic                        clock,
   input  bf3_pkg::ls_ctrl_type        ctrl,
   output logic [bf3_pkg::PIX_W-1:0]   prev_q,
   output logic [bf3_pkg::PIX_W-1:0]   prev2_q
);

   logic [bf3_pkg::PIX_W-1:0] line_prev  [bf3_pkg::MAX_WIDTH];
   logic [bf3_pkg::PIX_W-1:0] line_prev2 [bf3_pkg::MAX_WIDTH];
   logic [bf3_pkg::PIX_W-1:0] prev_q_ff;
   logic [bf3_pkg::PIX_W-1:0] prev2_q_ff;

   // The write belongs to the beat whose read is still held in prev_q_ff, so the
   // older row moves down into the second store as the new pixel lands.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         line_prev[ctrl.wr_addr]  <= ctrl.wr_pixel;
         line_prev2[ctrl.wr_addr] <= prev_q_ff;
      end
      if (ctrl.rd_en) begin
         prev_q_ff  <= line_prev[ctrl.rd_addr];
         prev2_q_ff <= line_prev2[ctrl.rd_addr];
      end
   end

   assign prev_q  = prev_q_ff;
   assign prev2_q = prev2_q_ff;

endmodule

@@ rtl/box_filter_3x3.sv @@
// Top level of the 3x3 box filter: position tracking, window and mean, result register.
//
// Pixels enter in raster order on req_ch, one beat per pixel (drain = 0). Each
// interior pixel leaves on rsp_ch as floor(sum of its 3x3 neighborhood / 9);
// pixels on the outer row or column on any side leave unchanged. Results carry
// their row and column and frame_end on the last pixel of the frame. Results
// trail the input by one row and one pixel, so after the last pixel of a frame
// the source sends image_width + 1 drain beats to push out the tail; a drain
// beat before the last pixel is dropped, and a pixel beat during the tail acts
// as a drain. After the frame_end result the next pixel starts a new frame.
// csr_ch writes image_width (index 0) and image_height (index 1), clamped to
// [3, 512]; a write restarts the frame and is meant only while the block is idle.
// A beat is accepted into an input register, which reads both line stores; as the
// beat leaves it, the window sum and the divide by nine land in the result
// register, which drives rsp_ch. One beat a cycle is taken as long as rsp_ch is
// not stalled. When the sink holds ready low the result waits in its register,
// one more beat is held in the input register, and req_ch.ready then drops.
// Reset sets 512 x 512, clears all counters and the window; the line stores are
// not cleared and need no pass.
module box_filter_3x3 (
   input  logic         clock,
   input  logic         reset,
   bf3_pixel_if.sink    req_ch,
   bf3_result_if.source rsp_ch,
   bf3_csr_if.sink      csr_ch
);

   localparam int DW = bf3_pkg::DIM_W;
   localparam int AW = bf3_pkg::ADDR_W;
   localparam int PW = bf3_pkg::PIX_W;
   localparam int QW = bf3_pkg::POS_W;

   // Frame size and position counters.
   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [DW-1:0] in_row_ff, in_row_in;
   logic [DW-1:0] in_col_ff, in_col_in;
   logic [QW-1:0] emit_row_ff, emit_row_in;
   logic [QW-1:0] emit_col_ff, emit_col_in;

   // Input register.
   logic          s1_valid_ff;
   logic          s1_emit_ff, s1_emit_in;
   logic          s1_wr_ff, s1_wr_in;
   logic          s1_lines_ok_ff, s1_lines_ok_in;
   logic [AW-1:0] s1_addr_ff;
   logic [PW-1:0] s1_pixel_ff;
   logic [QW-1:0] s1_row_ff;
   logic [QW-1:0] s1_col_ff;
   logic          s1_border_ff, s1_border_in;
   logic          s1_last_ff, s1_last_in;

   // Window held as the center pixel to come and two column sums.
   logic [PW-1:0]            center_ff;
   logic [bf3_pkg::COL_W-1:0] col1_sum_ff;
   logic [bf3_pkg::COL_W-1:0] col2_sum_ff;

   // Result register.
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [QW-1:0] rsp_row_ff;
   logic [QW-1:0] rsp_col_ff;
   logic          rsp_end_ff;

   logic          out_free;
   logic          s1_adv;
   logic          accept;
   logic          tail;
   logic          take;
   logic          started;
   logic          csr_write;
   logic [DW-1:0] row_adv;
   logic [DW-1:0] col_adv;
   logic [DW-1:0] hm1;
   logic [DW-1:0] wm1;
   logic [DW-1:0] ec_next;

   bf3_pkg::ls_ctrl_type ls_ctrl;
   logic [PW-1:0]        prev_q;
   logic [PW-1:0]        prev2_q;

   logic [PW-1:0]                    top_px;
   logic [PW-1:0]                    mid_px;
   logic [PW-1:0]                    bot_px;
   logic [bf3_pkg::COL_W-1:0]        col_sum;
   logic [bf3_pkg::SUM_W-1:0]        total;
   logic [bf3_pkg::PROD_W-1:0]       product;
   logic [PW-1:0]                    mean;

   // Handshakes: the input register moves on whenever the result register is free.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // A drain before the frame's last pixel is dropped.
   assign tail = (in_row_ff >= height_ff);
   assign take = accept && (tail || !req_ch.drain);

   // Next input position, result position and the border and last tests.
   always_comb begin
      hm1 = height_ff - DW'(1);
      wm1 = width_ff - DW'(1);
      if (tail) begin
         row_adv = in_row_ff;
         col_adv = in_col_ff + DW'(1);
      end else if (in_col_ff + DW'(1) >= width_ff) begin
         row_adv = in_row_ff + DW'(1);
         col_adv = '0;
      end else begin
         row_adv = in_row_ff;
         col_adv = in_col_ff + DW'(1);
      end
      started = tail || (row_adv >= DW'(2)) || ((row_adv == DW'(1)) && (col_adv >= DW'(2)));
      s1_border_in = (emit_row_ff == '0) || ({1'b0, emit_row_ff} >= hm1) ||
                     (emit_col_ff == '0) || ({1'b0, emit_col_ff} >= wm1);
      s1_last_in   = ({1'b0, emit_row_ff} >= hm1) && ({1'b0, emit_col_ff} >= wm1);
      s1_emit_in     = started;
      s1_wr_in       = !tail;
      s1_lines_ok_in = (in_col_ff < width_ff);
      ec_next        = {1'b0, emit_col_ff} + DW'(1);

      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (csr_write) begin
         case (csr_ch.index)
            bf3_pkg::CSR_IMAGE_WIDTH: begin
               width_in = bf3_pkg::clamp_dim(csr_ch.data, DW'(bf3_pkg::MAX_WIDTH));
            end
            bf3_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = bf3_pkg::clamp_dim(csr_ch.data, DW'(bf3_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
         if ((csr_ch.index == bf3_pkg::CSR_IMAGE_WIDTH) ||
             (csr_ch.index == bf3_pkg::CSR_IMAGE_HEIGHT)) begin
            in_row_in   = '0;
            in_col_in   = '0;
            emit_row_in = '0;
            emit_col_in = '0;
         end
      end else if (take) begin
         in_row_in = row_adv;
         in_col_in = col_adv;
         if (started) begin
            if (s1_last_in) begin
               in_row_in   = '0;
               in_col_in   = '0;
               emit_row_in = '0;
               emit_col_in = '0;
            end else if (ec_next >= width_ff) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + QW'(1);
            end else begin
               emit_col_in = ec_next[QW-1:0];
            end
         end
      end
   end

   // Line stores are read as a beat is taken and written as it leaves.
   always_comb begin
      ls_ctrl.rd_en    = take;
      ls_ctrl.rd_addr  = in_col_ff[AW-1:0];
      ls_ctrl.wr_en    = s1_adv && s1_wr_ff;
      ls_ctrl.wr_addr  = s1_addr_ff;
      ls_ctrl.wr_pixel = s1_pixel_ff;
   end

   bf3_line_store u_line_store (
      .clock   (clock),
      .ctrl    (ls_ctrl),
      .prev_q  (prev_q),
      .prev2_q (prev2_q)
   );

   // New window column, nine-pixel sum and the divide by nine.
   always_comb begin
      top_px  = s1_lines_ok_ff ? prev2_q : '0;
      mid_px  = s1_lines_ok_ff ? prev_q : '0;
      bot_px  = s1_wr_ff ? s1_pixel_ff : '0;
      col_sum = bf3_pkg::COL_W'(top_px) + bf3_pkg::COL_W'(mid_px) +
                bf3_pkg::COL_W'(bot_px);
      total   = bf3_pkg::SUM_W'(col1_sum_ff) + bf3_pkg::SUM_W'(col2_sum_ff) +
                bf3_pkg::SUM_W'(col_sum);
      product = bf3_pkg::PROD_W'(total) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_NINE);
      mean    = product[bf3_pkg::RECIP_SHIFT +: PW];
      rsp_pixel_in = s1_border_ff ? center_ff : mean;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DW'(bf3_pkg::MAX_WIDTH);
         height_ff    <= DW'(bf3_pkg::MAX_HEIGHT);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         center_ff    <= '0;
         col1_sum_ff  <= '0;
         col2_sum_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && s1_emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // The window slides one column per beat that leaves the input register.
         if (s1_adv) begin
            center_ff   <= mid_px;
            col1_sum_ff <= col2_sum_ff;
            col2_sum_ff <= col_sum;
         end
      end
   end

   // Payload of the input and result registers.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_emit_ff     <= s1_emit_in;
         s1_wr_ff       <= s1_wr_in;
         s1_lines_ok_ff <= s1_lines_ok_in;
         s1_addr_ff     <= in_col_ff[AW-1:0];
         s1_pixel_ff    <= req_ch.pixel_in;
         s1_row_ff      <= emit_row_ff;
         s1_col_ff      <= emit_col_ff;
         s1_border_ff   <= s1_border_in;
         s1_last_ff     <= s1_last_in;
      end
      if (s1_adv && s1_emit_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
         rsp_end_ff   <= s1_last_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pixel_out = rsp_pixel_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.frame_end = rsp_end_ff;

   // A beat held in the input register stays there until it can move on.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("input register lost a beat while blocked");

   // With both registers full and the sink stalled, no beat is taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("beat taken while the pipeline is full");

   // The next result column always lies inside the row.
   a_emit_col_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, emit_col_ff} < width_ff))
      else $error("result column counter beyond image width");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("result pending after reset");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of box_filter_3x3: a mean predictor, a result scoreboard and stream drivers.

// One filtered pixel as it leaves the block.
typedef struct packed {
   logic [bf3_pkg::PIX_W-1:0] pixel;
   logic [bf3_pkg::POS_W-1:0] row;
   logic [bf3_pkg::POS_W-1:0] col;
   logic                      frame_end;
} filtered_pixel_type;

// Predicts the smoothed stream beat by beat and checks results against it in order.
class smoothing_scoreboard;
   int unsigned        width;
   int unsigned        height;
   logic [7:0]         row_above  [bf3_pkg::MAX_WIDTH];
   logic [7:0]         row_above2 [bf3_pkg::MAX_WIDTH];
   logic [7:0]         win [3][3];
   int unsigned        in_row;
   int unsigned        in_col;
   int unsigned        emit_row;
   int unsigned        emit_col;
   filtered_pixel_type awaited[$];
   bit                 failed;

   function new();
      width  = bf3_pkg::MAX_WIDTH;
      height = bf3_pkg::MAX_HEIGHT;
      foreach (row_above[i]) begin
         row_above[i]  = '0;
         row_above2[i] = '0;
      end
      foreach (win[i, j]) begin
         win[i][j] = '0;
      end
      failed = 1'b0;
      restart();
   endfunction

   function void restart();
      in_row   = 0;
      in_col   = 0;
      emit_row = 0;
      emit_col = 0;
   endfunction

   function int unsigned pending();
      return awaited.size();
   endfunction

   // A register write clamps the dimension into [3, max] and restarts the frame.
   function void set_dim(bf3_pkg::csr_index_type idx, logic [bf3_pkg::DIM_W-1:0] value);
      int unsigned v;
      int unsigned limit;
      v = value;
      limit = (idx == bf3_pkg::CSR_IMAGE_WIDTH) ? bf3_pkg::MAX_WIDTH : bf3_pkg::MAX_HEIGHT;
      if (v < bf3_pkg::MIN_DIM) begin
         v = bf3_pkg::MIN_DIM;
      end else if (v > limit) begin
         v = limit;
      end
      if (idx == bf3_pkg::CSR_IMAGE_WIDTH) begin
         width = v;
      end else begin
         height = v;
      end
      restart();
   endfunction

   // Advances the window for one accepted beat and queues the result it causes, if any.
   function void take_beat(logic [7:0] pixel, logic drain_bit);
      int unsigned r;
      int unsigned c;
      int unsigned er;
      int unsigned ec;
      int unsigned sum;
      bit          tail;
      bit          is_last;
      logic [7:0]  top;
      logic [7:0]  mid;
      logic [7:0]  bot;
      logic [7:0]  val;
      filtered_pixel_type res;

      r = in_row;
      c = in_col;
      tail = (r >= height);
      // A drain before the frame's last pixel is dropped.
      if (!tail && drain_bit) begin
         return;
      end

      top = '0;
      mid = '0;
      bot = '0;
      if (c < width && c < bf3_pkg::MAX_WIDTH) begin
         top = row_above2[c];
         mid = row_above[c];
      end
      // During the tail a pixel beat acts as a drain and its pixel is lost.
      if (!tail) begin
         bot = pixel;
         if (c < bf3_pkg::MAX_WIDTH) begin
            row_above2[c] = mid;
            row_above[c]  = bot;
         end
      end
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;

      if (tail) begin
         in_col = c + 1;
      end else begin
         c++;
         if (c >= width) begin
            c = 0;
            r++;
         end
         in_row = r;
         in_col = c;
      end

      // Nothing leaves until the input has passed row 1, column 1.
      if (!tail && !(in_row >= 2 || (in_row == 1 && in_col >= 2))) begin
         return;
      end

      er = emit_row;
      ec = emit_col;
      if (er == 0 || er >= height - 1 || ec == 0 || ec >= width - 1) begin
         val = win[1][1];
      end else begin
         sum = 0;
         foreach (win[i, j]) begin
            sum += win[i][j];
         end
         val = 8'(sum / 9);
      end
      is_last = (er >= height - 1 && ec >= width - 1);

      res.pixel     = val;
      res.row       = bf3_pkg::POS_W'(er);
      res.col       = bf3_pkg::POS_W'(ec);
      res.frame_end = is_last;
      awaited.push_back(res);

      if (is_last) begin
         restart();
      end else begin
         ec++;
         if (ec >= width) begin
            ec = 0;
            er++;
         end
         emit_row = er;
         emit_col = ec;
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got,
                               filtered_pixel_type at);
      if (want != got) begin
         $display("%0t: %s at row %0d col %0d: expected %0d, actual %0d",
                  $time, name, at.row, at.col, want, got);
         failed = 1'b1;
      end
   endfunction

   // Checks one result beat against the oldest expectation.
   function void check_filtered(filtered_pixel_type got);
      filtered_pixel_type want;
      if (awaited.size() == 0) begin
         $display("%0t: result with nothing expected: expected none, actual pixel %0d row %0d col %0d",
                  $time, got.pixel, got.row, got.col);
         failed = 1'b1;
         return;
      end
      want = awaited.pop_front();
      compare_field("pixel_out", want.pixel, got.pixel, want);
      compare_field("out_row", want.row, got.row, want);
      compare_field("out_col", want.col, got.col, want);
      compare_field("frame_end", want.frame_end, got.frame_end, want);
   endfunction
endclass

module tb_top;

   localparam int unsigned GAP_PCT        = 36;
   localparam int unsigned IDLE_GAP       = 4;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned RANDOM_BEATS   = 180;

   logic        clock = 1'b0;
   logic        reset;
   bit          gaps_on = 1'b1;
   int unsigned stall_cycles = 0;
   int unsigned counted_beats;

   smoothing_scoreboard sb = new();

   bf3_pixel_if  req_if ();
   bf3_result_if rsp_if ();
   bf3_csr_if    csr_if ();

   box_filter_3x3 u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result sink: ready drops at random while gaps are on.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
      end
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_filtered(filtered_pixel_type'{rsp_if.pixel_out, rsp_if.out_row,
                                                rsp_if.out_col, rsp_if.frame_end});
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("box_filter_3x3 verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offers one beat, with random idle cycles ahead of it, and waits for acceptance.
   task automatic send_beat(input logic [7:0] pixel, input logic drain_bit);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.pixel_in <= pixel;
      req_if.drain    <= drain_bit;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sb.take_beat(pixel, drain_bit);
   endtask

   // Waits for every expected result, then idles so a beat with no result can leave.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // Writes the chosen dimension registers once the block is idle.
   task automatic write_regs(input bit write_w, input logic [bf3_pkg::DIM_W-1:0] w_raw,
                             input bit write_h, input logic [bf3_pkg::DIM_W-1:0] h_raw);
      bf3_pkg::csr_index_type idx;
      settle();
      for (int k = 0; k < 2; k++) begin
         if (k == 0 ? write_w : write_h) begin
            idx = (k == 0) ? bf3_pkg::CSR_IMAGE_WIDTH : bf3_pkg::CSR_IMAGE_HEIGHT;
            csr_if.valid <= 1'b1;
            csr_if.index <= idx;
            csr_if.data  <= (k == 0) ? w_raw : h_raw;
            @(posedge clock);
            while (!csr_if.ready) begin
               @(posedge clock);
            end
            sb.set_dim(idx, (k == 0) ? w_raw : h_raw);
         end
      end
      csr_if.valid <= 1'b0;
   endtask

   // Streams one frame at the current size and its drain tail; may stop partway.
   task automatic stream_frame(input bit noisy, input bit may_cut, output bit whole);
      int unsigned w;
      int unsigned total;
      int unsigned stop;
      w     = sb.width;
      total = sb.width * sb.height;
      stop  = total;
      if (may_cut && $urandom_range(9) == 0) begin
         stop = $urandom_range(total - 1);
      end
      for (int unsigned i = 0; i < stop; i++) begin
         if (noisy && $urandom_range(19) == 0) begin
            send_beat(pick_pixel(), 1'b1);
         end
         send_beat(pick_pixel(), 1'b0);
         counted_beats++;
      end
      whole = (stop == total);
      if (whole) begin
         // The tail takes width + 1 beats; a pixel beat there counts as a drain.
         for (int unsigned i = 0; i <= w; i++) begin
            send_beat(pick_pixel(), !(noisy && $urandom_range(7) == 0));
            counted_beats++;
         end
         if (noisy && $urandom_range(5) == 0) begin
            send_beat(pick_pixel(), 1'b1);
         end
      end
   endtask

   initial begin
      int unsigned frame_no;
      bit          whole;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.pixel_in <= '0;
      req_if.drain    <= 1'b0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= bf3_pkg::CSR_IMAGE_WIDTH;
      csr_if.data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at 3 x 3, set from values below the legal range.
      write_regs(1'b1, 10'd0, 1'b1, 10'd2);
      send_beat(8'hFF, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_beat(8'hFF, 1'b0);
      end
      send_beat(8'h00, 1'b1);
      send_beat(8'h5A, 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat(8'h00, 1'b1);
      // A drain right after the frame end starts nothing.
      send_beat(8'hA5, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_beat((i == 4) ? 8'h80 : ((i % 2) ? 8'hFF : 8'h00), 1'b0);
      end
      repeat (4) send_beat(8'h00, 1'b1);

      // Largest size, set from over-range values; the frame is cut short by the next write.
      write_regs(1'b1, 10'd1023, 1'b1, 10'd1023);
      for (int i = 0; i < 530; i++) begin
         send_beat(pick_pixel(), 1'b0);
      end

      // A full 24 x 3 frame with no idling on either side.
      gaps_on = 1'b0;
      write_regs(1'b1, 10'd24, 1'b1, 10'd0);
      stream_frame(1'b0, 1'b0, whole);
      gaps_on = 1'b1;

      // A full 3 x 40 frame.
      write_regs(1'b1, 10'd1, 1'b1, 10'd40);
      stream_frame(1'b1, 1'b0, whole);

      // Random small frames with noise, broken frames and occasional gap-free stretches.
      counted_beats = 0;
      frame_no = 0;
      whole = 1'b0;
      while (counted_beats < RANDOM_BEATS) begin
         if (!whole || $urandom_range(2) == 0) begin
            write_regs(1'b1, ($urandom_range(7) == 0) ? 10'($urandom_range(40))
                                                     : 10'($urandom_range(14)),
                       $urandom_range(1), 10'($urandom_range(12)));
         end
         gaps_on = ((frame_no % 12) != 7);
         stream_frame(1'b1, 1'b1, whole);
         frame_no++;
      end
      gaps_on = 1'b1;

      settle();
      if (!sb.failed && sb.pending() == 0) begin
         $display("box_filter_3x3 verification clean");
      end else begin
         $display("box_filter_3x3 verification failed");
      end
      $finish;
   end
endmodule

@@ box_filter_3x3.f @@
rtl/bf3_pkg.sv
rtl/bf3_channels.sv
rtl/bf3_line_store.sv
rtl/box_filter_3x3.sv
test/tb_top.sv
